@@ rtl/smavg_pkg.sv @@
// Shared types and constants for the simple moving average block.
// Depends on nothing; the interfaces and simple_moving_average refer to it by scoped names.
package smavg_pkg;

	localparam int WINDOW_MAX = 256;
	localparam int SAMPLE_W   = 32;
	localparam int ADDR_W     = $clog2(WINDOW_MAX);
	localparam int LEN_W      = $clog2(WINDOW_MAX) + 1;
	localparam int SUM_W      = SAMPLE_W + ADDR_W;
	localparam int DIV_STEPS  = SUM_W;
	localparam int STEP_W     = $clog2(DIV_STEPS);

	localparam int APB_DATA_W = 32;
	localparam int APB_ADDR_W = 3;

	// Register index, taken from paddr[2].
	localparam logic REG_WINDOW_LEN = 1'b0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUB,
		ST_ADD,
		ST_PREP,
		ST_DIV,
		ST_FIX,
		ST_DONE
	} state_t;

endpackage

@@ rtl/smavg_in_if.sv @@
// Input channel of the moving average block: one sample word per handshake.
// Depends on smavg_pkg.
interface smavg_in_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [smavg_pkg::SAMPLE_W-1:0] sample;
	logic                                 end_of_series;

	modport source (output valid, output sample, output end_of_series, input ready);
	modport sink (input valid, input sample, input end_of_series, output ready);
endinterface

@@ rtl/smavg_out_if.sv @@
// Output channel of the moving average block: one average word per handshake.
// Depends on smavg_pkg.
interface smavg_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [smavg_pkg::SAMPLE_W-1:0] average;
	logic                                 average_valid;
	logic                                 series_end;

	modport source (output valid, output average, output average_valid,
		output series_end, input ready);
	modport sink (input valid, input average, input average_valid,
		input series_end, output ready);
endinterface

@@ rtl/smavg_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// Depends on nothing.
module smavg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ rtl/simple_moving_average.sv @@
// Simple moving average over a sliding window of signed Q16.16 sample words.
// Depends on smavg_pkg, smavg_in_if, smavg_out_if and smavg_ram.
//
// The block keeps the last window_len samples of a series in a 256-entry ring
// RAM and a 40-bit running sum. For each accepted sample it subtracts the
// sample that leaves the window, adds the new one, and returns the sum divided
// by window_len, truncated toward zero. The first window_len-1 results of a
// series are zero with average_valid clear. A sample with end_of_series set
// restarts the series after its own result, and so does any write of
// window_len (only pwdata[8:0] is kept; 0 acts as 1, values above 256 as 256).
// One sample is in work at a time: a sample that yields a valid average
// passes through a 40-step restoring divider that produces one quotient bit
// per cycle before its result word is offered; a warm-up sample skips the
// divider. The input is ready again in the cycle in which the result word is
// first offered, even while that word still waits to be taken downstream, so
// the next sample can be accepted in the cycle after the load. Configuration
// is written through an APB-style port with window_len at byte address 0;
// pready is always high.
module simple_moving_average (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 psel,
	input  logic                                 penable,
	input  logic                                 pwrite,
	input  logic [smavg_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [smavg_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [smavg_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                 pready,
	smavg_in_if.sink                             samples,
	smavg_out_if.source                          results
);

	localparam int SAMPLE_W = smavg_pkg::SAMPLE_W;
	localparam int SUM_W    = smavg_pkg::SUM_W;
	localparam int LEN_W    = smavg_pkg::LEN_W;
	localparam int ADDR_W   = smavg_pkg::ADDR_W;
	localparam int STEP_W   = smavg_pkg::STEP_W;

	// Configuration register and its effective value.
	logic [LEN_W-1:0] window_len_q;
	logic [LEN_W-1:0] len_eff;
	logic             cfg_write;

	// Series state.
	logic signed [SUM_W-1:0] sum_q;
	logic [LEN_W-1:0]        fill_q;
	logic [ADDR_W-1:0]       slot_q;

	// Captured sample and flags of the word in work.
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       eos_q;
	logic                       sub_q;
	logic                       avg_valid_q;

	// Divider.
	logic [SUM_W-1:0]  dvd_q;
	logic [LEN_W-1:0]  rem_q;
	logic [STEP_W-1:0] step_q;
	logic              neg_q;
	logic [LEN_W:0]    trial;
	logic [LEN_W:0]    diff;
	logic [SAMPLE_W-1:0] avg_q;

	// Sequencer.
	smavg_pkg::state_t state_q;
	smavg_pkg::state_t state_d;
	logic              in_fire;
	logic              out_load;

	// Ring RAM.
	logic [SAMPLE_W-1:0] ram_rdata;
	logic [ADDR_W-1:0]   old_slot;

	logic [LEN_W-1:0]    fill_next;

	// ---------------------------------------------------------------------
	// APB-style configuration port. Writes are taken in the access phase.
	// ---------------------------------------------------------------------
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready &&
		(paddr[2] == smavg_pkg::REG_WINDOW_LEN);
	assign prdata    = (paddr[2] == smavg_pkg::REG_WINDOW_LEN) ?
		smavg_pkg::APB_DATA_W'(window_len_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= LEN_W'(1);
		end else if (cfg_write) begin
			window_len_q <= pwdata[LEN_W-1:0];
		end
	end

	// A zero length acts as one, anything above the ring depth as the depth.
	always_comb begin
		if (window_len_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (window_len_q > LEN_W'(smavg_pkg::WINDOW_MAX)) begin
			len_eff = LEN_W'(smavg_pkg::WINDOW_MAX);
		end else begin
			len_eff = window_len_q;
		end
	end

	// The slot leaving the window lies len_eff entries behind the write slot,
	// modulo the ring depth; a full-depth window wraps onto the write slot.
	assign old_slot = slot_q - len_eff[ADDR_W-1:0];

	// ---------------------------------------------------------------------
	// Sequencer: next state and handshake strobes.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= smavg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		samples.ready = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			smavg_pkg::ST_IDLE: begin
				samples.ready = 1'b1;
				if (samples.valid) begin
					state_d = smavg_pkg::ST_SUB;
				end
			end
			smavg_pkg::ST_SUB: begin
				state_d = smavg_pkg::ST_ADD;
			end
			smavg_pkg::ST_ADD: begin
				// Warm-up results skip the divider altogether.
				if (fill_next >= len_eff) begin
					state_d = smavg_pkg::ST_PREP;
				end else begin
					state_d = smavg_pkg::ST_DONE;
				end
			end
			smavg_pkg::ST_PREP: begin
				state_d = smavg_pkg::ST_DIV;
			end
			smavg_pkg::ST_DIV: begin
				if (step_q == '0) begin
					state_d = smavg_pkg::ST_FIX;
				end
			end
			smavg_pkg::ST_FIX: begin
				state_d = smavg_pkg::ST_DONE;
			end
			smavg_pkg::ST_DONE: begin
				// Wait until the output register is free or being emptied.
				if (!results.valid || results.ready) begin
					out_load = 1'b1;
					state_d  = smavg_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = smavg_pkg::ST_IDLE;
			end
		endcase
	end

	assign in_fire = samples.valid && samples.ready;

	// ---------------------------------------------------------------------
	// Ring RAM. The leaving sample is read at acceptance and arrives in
	// ST_SUB, where the new sample is written; read and write never share a
	// cycle, so a full-depth window needs no bypass.
	// ---------------------------------------------------------------------
	smavg_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (smavg_pkg::WINDOW_MAX)
	) u_ring (
		.clk   (clk),
		.we    (state_q == smavg_pkg::ST_SUB),
		.waddr (slot_q),
		.wdata (sample_q),
		.re    (in_fire),
		.raddr (old_slot),
		.rdata (ram_rdata)
	);

	// ---------------------------------------------------------------------
	// Capture of the accepted word.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_fire) begin
			sample_q <= samples.sample;
			eos_q    <= samples.end_of_series;
			// Only a full window drops its oldest entry, so every entry subtracted
			// was written earlier in the same series.
			sub_q    <= (fill_q >= len_eff);
		end
	end

	assign fill_next = (fill_q < len_eff) ? fill_q + LEN_W'(1) : fill_q;

	// ---------------------------------------------------------------------
	// Running sum, fill count and write slot. A configuration write or the
	// end of a series clears all three.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			fill_q <= '0;
			slot_q <= '0;
		end else if (cfg_write || (out_load && eos_q)) begin
			sum_q  <= '0;
			fill_q <= '0;
			slot_q <= '0;
		end else if (state_q == smavg_pkg::ST_SUB) begin
			if (sub_q) begin
				sum_q <= sum_q - {{(SUM_W-SAMPLE_W){ram_rdata[SAMPLE_W-1]}}, ram_rdata};
			end
		end else if (state_q == smavg_pkg::ST_ADD) begin
			sum_q  <= sum_q + {{(SUM_W-SAMPLE_W){sample_q[SAMPLE_W-1]}}, sample_q};
			fill_q <= fill_next;
			slot_q <= slot_q + ADDR_W'(1);
		end
	end

	// ---------------------------------------------------------------------
	// Restoring divider on the magnitude of the sum, one quotient bit per
	// cycle. The dividend register shifts the quotient in from the right.
	// ---------------------------------------------------------------------
	assign trial = {rem_q, dvd_q[SUM_W-1]};
	assign diff  = trial - {1'b0, len_eff};

	always_ff @(posedge clk) begin
		case (state_q)
			smavg_pkg::ST_ADD: begin
				avg_valid_q <= (fill_next >= len_eff);
			end
			smavg_pkg::ST_PREP: begin
				neg_q  <= sum_q[SUM_W-1];
				dvd_q  <= sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
				rem_q  <= '0;
				step_q <= STEP_W'(smavg_pkg::DIV_STEPS - 1);
			end
			smavg_pkg::ST_DIV: begin
				if (!diff[LEN_W]) begin
					rem_q <= diff[LEN_W-1:0];
					dvd_q <= {dvd_q[SUM_W-2:0], 1'b1};
				end else begin
					rem_q <= trial[LEN_W-1:0];
					dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
				end
				step_q <= step_q - STEP_W'(1);
			end
			smavg_pkg::ST_FIX: begin
				// The mean lies within the sample range, so the low bits hold it.
				avg_q <= neg_q ? (~dvd_q[SAMPLE_W-1:0] + SAMPLE_W'(1)) : dvd_q[SAMPLE_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// ---------------------------------------------------------------------
	// Output register. Its valid flag is control state; the payload is not.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			results.valid <= 1'b0;
		end else if (out_load) begin
			results.valid <= 1'b1;
		end else if (results.ready) begin
			results.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			results.average       <= avg_valid_q ? avg_q : '0;
			results.average_valid <= avg_valid_q;
			results.series_end    <= eos_q;
		end
	end

endmodule
